FILE: design/sulist_pkg.sv
// Package: shared types and constants of the sorted unique list unit.
`default_nettype none

package sulist_pkg;

    localparam int CAPACITY  = 16;
    localparam int DATA_W    = 32;
    localparam int CMD_W     = 3;
    localparam int POS_W     = 5;
    localparam int STAT_W    = 2;
    localparam int CNT_W     = 5;
    localparam int IDX_W     = 4;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    localparam int S_CMD_LSB = 0;
    localparam int S_VAL_LSB = S_CMD_LSB + CMD_W;
    localparam int S_POS_LSB = S_VAL_LSB + DATA_W;

    localparam int M_ITEM_LSB  = 0;
    localparam int M_STAT_LSB  = M_ITEM_LSB + DATA_W;
    localparam int M_FOUND_LSB = M_STAT_LSB + STAT_W;
    localparam int M_CNT_LSB   = M_FOUND_LSB + POS_W;
    localparam int M_USED_W    = M_CNT_LSB + CNT_W;

    localparam logic [DATA_W-1:0] ITEM_NONE = '1;
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(CAPACITY);

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_GET    = 3'd2,
        CMD_SEARCH = 3'd3,
        CMD_CLEAR  = 3'd4
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_MISS  = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_FULL  = 2'd3
    } stat_t;

    typedef struct packed {
        logic load;
        logic apply;
    } sulist_ctl_t;

endpackage

`default_nettype wire

FILE: design/sulist_ctrl.sv
// Controller: accept and apply sequencing with the output valid flag.
`default_nettype none

module sulist_ctrl (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire                     out_ready,
    output sulist_pkg::sulist_ctl_t ctl
);

    typedef enum logic {
        ST_IDLE,
        ST_APPLY
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        ctl.load  = in_valid && (state_reg == ST_IDLE);
        ctl.apply = (state_reg == ST_APPLY) && (!out_valid_reg || out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.apply)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (ctl.load)
                    begin
                        state_reg <= ST_APPLY;
                    end
                end
                ST_APPLY:
                begin
                    if (ctl.apply)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: design/sulist_dp.sv
// Datapath: cell chain of entries with parallel compare, shift and result register.
`default_nettype none

module sulist_dp (
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  sulist_pkg::sulist_ctl_t                 ctl,
    input  wire  [sulist_pkg::S_TDATA_W-1:0]        in_data,
    output logic [sulist_pkg::M_TDATA_W-1:0]        out_data
);

    logic [sulist_pkg::DATA_W-1:0]   entries_reg [sulist_pkg::CAPACITY];
    logic [sulist_pkg::DATA_W-1:0]   entries_next [sulist_pkg::CAPACITY];
    logic [sulist_pkg::CNT_W-1:0]    count_reg;
    logic [sulist_pkg::CNT_W-1:0]    count_next;

    logic [sulist_pkg::CMD_W-1:0]    cmd_reg;
    logic [sulist_pkg::DATA_W-1:0]   value_reg;
    logic [sulist_pkg::POS_W-1:0]    pos_reg;
    logic [sulist_pkg::CAPACITY-1:0] gt_reg;
    logic [sulist_pkg::CAPACITY-1:0] gt_next;
    logic [sulist_pkg::CAPACITY-1:0] eq_reg;
    logic [sulist_pkg::CAPACITY-1:0] eq_next;

    logic [sulist_pkg::DATA_W-1:0]   item_reg;
    logic [sulist_pkg::DATA_W-1:0]   item_next;
    logic [sulist_pkg::STAT_W-1:0]   stat_reg;
    logic [sulist_pkg::STAT_W-1:0]   stat_next;
    logic [sulist_pkg::POS_W-1:0]    found_reg;
    logic [sulist_pkg::POS_W-1:0]    found_next;
    logic [sulist_pkg::CNT_W-1:0]    cnt_out_reg;

    logic [sulist_pkg::DATA_W-1:0]   in_value;
    logic [sulist_pkg::CAPACITY:0]   gt_prev;
    logic [sulist_pkg::POS_W-1:0]    slot;
    logic [sulist_pkg::POS_W-1:0]    hit;
    logic                            dup;
    logic                            pos_ok;
    logic [sulist_pkg::IDX_W-1:0]    get_idx;
    logic [sulist_pkg::POS_W-1:0]    pos_minus;

    assign in_value  = in_data[sulist_pkg::S_VAL_LSB +: sulist_pkg::DATA_W];
    assign gt_prev   = {gt_reg, 1'b1};
    assign pos_minus = pos_reg - sulist_pkg::POS_W'(1);
    assign get_idx   = pos_minus[sulist_pkg::IDX_W-1:0];
    assign pos_ok    = (pos_reg != '0) && (pos_reg <= count_reg);
    assign dup       = |eq_reg;

    always_comb
    begin
        for (int i = 0; i < sulist_pkg::CAPACITY; i++)
        begin
            gt_next[i] = (sulist_pkg::CNT_W'(i) < count_reg)
                && ($signed(entries_reg[i]) > $signed(in_value));
            eq_next[i] = (sulist_pkg::CNT_W'(i) < count_reg)
                && (entries_reg[i] == in_value);
        end
    end

    always_comb
    begin
        slot = '0;
        hit  = '0;
        for (int i = 0; i < sulist_pkg::CAPACITY; i++)
        begin
            if (gt_prev[i] && !gt_reg[i])
            begin
                slot = slot | sulist_pkg::POS_W'(i + 1);
            end
            if (eq_reg[i])
            begin
                hit = hit | sulist_pkg::POS_W'(i + 1);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < sulist_pkg::CAPACITY; i++)
        begin
            entries_next[i] = entries_reg[i];
        end
        count_next = count_reg;
        item_next  = '0;
        stat_next  = sulist_pkg::STAT_OK;
        found_next = '0;
        case (cmd_reg)
            sulist_pkg::CMD_INSERT:
            begin
                if (dup)
                begin
                    stat_next = sulist_pkg::STAT_MISS;
                end
                else if (count_reg == sulist_pkg::CNT_FULL)
                begin
                    stat_next = sulist_pkg::STAT_FULL;
                end
                else
                begin
                    if (!gt_reg[0])
                    begin
                        entries_next[0] = value_reg;
                    end
                    for (int i = 1; i < sulist_pkg::CAPACITY; i++)
                    begin
                        if (!gt_reg[i])
                        begin
                            entries_next[i] = gt_prev[i] ? value_reg : entries_reg[i-1];
                        end
                    end
                    count_next = count_reg + sulist_pkg::CNT_W'(1);
                    found_next = slot;
                end
            end
            sulist_pkg::CMD_REMOVE:
            begin
                if (pos_ok)
                begin
                    for (int i = 0; i < sulist_pkg::CAPACITY - 1; i++)
                    begin
                        if (sulist_pkg::POS_W'(i + 1) >= pos_reg)
                        begin
                            entries_next[i] = entries_reg[i+1];
                        end
                    end
                    count_next = count_reg - sulist_pkg::CNT_W'(1);
                end
                else
                begin
                    stat_next = sulist_pkg::STAT_RANGE;
                end
            end
            sulist_pkg::CMD_GET:
            begin
                if (pos_ok)
                begin
                    item_next = entries_reg[get_idx];
                end
                else
                begin
                    item_next = sulist_pkg::ITEM_NONE;
                    stat_next = sulist_pkg::STAT_RANGE;
                end
            end
            sulist_pkg::CMD_SEARCH:
            begin
                if (dup)
                begin
                    found_next = hit;
                end
                else
                begin
                    stat_next = sulist_pkg::STAT_MISS;
                end
            end
            sulist_pkg::CMD_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg   <= in_data[sulist_pkg::S_CMD_LSB +: sulist_pkg::CMD_W];
            value_reg <= in_value;
            pos_reg   <= in_data[sulist_pkg::S_POS_LSB +: sulist_pkg::POS_W];
            gt_reg    <= gt_next;
            eq_reg    <= eq_next;
        end
        if (ctl.apply)
        begin
            for (int i = 0; i < sulist_pkg::CAPACITY; i++)
            begin
                entries_reg[i] <= entries_next[i];
            end
            item_reg    <= item_next;
            stat_reg    <= stat_next;
            found_reg   <= found_next;
            cnt_out_reg <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctl.apply)
        begin
            count_reg <= count_next;
        end
    end

    assign out_data = {
        (sulist_pkg::M_TDATA_W - sulist_pkg::M_USED_W)'(0),
        cnt_out_reg,
        found_reg,
        stat_reg,
        item_reg
    };

endmodule

`default_nettype wire

FILE: design/sorted_unique_list_descending_unit.sv
// Top level: sorted unique list, descending order, stream in and out.
// Sequencing: a transaction is captured in the accept step and its result is
// registered in the apply step; a new transaction is taken only after the
// previous one is applied, and a held result stalls the apply step.
// Reset: clears the entry count and the handshake state; entry cells are not
// cleared and hold unknown values until written.
`default_nettype none

module sorted_unique_list_descending_unit (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // command[2:0], value[34:3], position[39:35]
    input  wire  [sulist_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // item[31:0], status[33:32], found_position[38:34], entry_count[43:39], zero
    output logic [sulist_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

    sulist_pkg::sulist_ctl_t ctl;

    sulist_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .ctl       (ctl)
    );

    sulist_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .in_data  (s_axis_tdata),
        .out_data (m_axis_tdata)
    );

endmodule

`default_nettype wire

FILE: design/sulist_checker.sv
// Checker: port-level properties of the sorted unique list unit, with its bind.
`default_nettype none

module sulist_checker (
    input wire                              clk,
    input wire                              rst_n,
    input wire                              s_axis_tvalid,
    input wire                              s_axis_tready,
    input wire                              m_axis_tvalid,
    input wire                              m_axis_tready,
    input wire [sulist_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    logic [sulist_pkg::POS_W-1:0]  found;
    logic [sulist_pkg::CNT_W-1:0]  count;
    logic [sulist_pkg::STAT_W-1:0] stat;

    assign found = m_axis_tdata[sulist_pkg::M_FOUND_LSB +: sulist_pkg::POS_W];
    assign count = m_axis_tdata[sulist_pkg::M_CNT_LSB +: sulist_pkg::CNT_W];
    assign stat  = m_axis_tdata[sulist_pkg::M_STAT_LSB +: sulist_pkg::STAT_W];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_one_per_two: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("transaction accepted in back-to-back cycles");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> count <= sulist_pkg::CNT_FULL)
        else $error("entry count above capacity");

    a_found_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && found != '0 |-> found <= count && stat == sulist_pkg::STAT_OK)
        else $error("found position inconsistent with count or status");

endmodule

bind sorted_unique_list_descending_unit sulist_checker u_sulist_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

FILE: bench/tb.sv
// Testbench: sorted unique descending list unit, checked against a local predictor.
`timescale 1ns / 100ps

module tb;

    localparam logic [sulist_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [sulist_pkg::CMD_W-1:0] CMD_SPARE_MID = 3'd6;
    localparam logic [sulist_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;
    localparam logic signed [sulist_pkg::DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [sulist_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam int RANDOM_OPS = 450;

    typedef struct packed {
        logic [sulist_pkg::POS_W-1:0]         pos;
        logic signed [sulist_pkg::DATA_W-1:0] value;
        logic [sulist_pkg::CMD_W-1:0]         cmd;
    } list_op_t;

    typedef struct packed {
        logic [sulist_pkg::M_TDATA_W-sulist_pkg::M_USED_W-1:0] pad;
        logic [sulist_pkg::CNT_W-1:0]                          count;
        logic [sulist_pkg::POS_W-1:0]                          found;
        sulist_pkg::stat_t                                     status;
        logic signed [sulist_pkg::DATA_W-1:0]                  item;
    } list_res_t;

    typedef struct {
        list_op_t  op;
        bit        typed;
        list_res_t res;
    } op_row_t;

    logic                               clk;
    logic                               rst_n;
    logic                               s_axis_tvalid;
    logic                               s_axis_tready;
    logic [sulist_pkg::S_TDATA_W-1:0]   s_axis_tdata;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready;
    logic [sulist_pkg::M_TDATA_W-1:0]   m_axis_tdata;

    logic signed [sulist_pkg::DATA_W-1:0] held_vals [sulist_pkg::CAPACITY];
    int                                   held_count;
    list_res_t                            pending_results [$];
    op_row_t                              op_table [$];
    int                                   errors;
    bit                                   calm;

    sorted_unique_list_descending_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic list_op_t mk_op(input logic [sulist_pkg::CMD_W-1:0] cmd,
                                       input logic signed [sulist_pkg::DATA_W-1:0] value,
                                       input logic [sulist_pkg::POS_W-1:0] pos);
        list_op_t op;
        op.cmd   = cmd;
        op.value = value;
        op.pos   = pos;
        return op;
    endfunction

    function automatic list_res_t mk_res(input logic signed [sulist_pkg::DATA_W-1:0] item,
                                         input sulist_pkg::stat_t status,
                                         input logic [sulist_pkg::POS_W-1:0] found,
                                         input logic [sulist_pkg::CNT_W-1:0] count);
        list_res_t r;
        r        = '0;
        r.item   = item;
        r.status = status;
        r.found  = found;
        r.count  = count;
        return r;
    endfunction

    function automatic void add_row(input list_op_t op, input bit typed, input list_res_t res);
        op_row_t row;
        row.op    = op;
        row.typed = typed;
        row.res   = res;
        op_table.push_back(row);
    endfunction

    function automatic list_res_t apply_op(input list_op_t op);
        list_res_t                            r;
        logic signed [sulist_pkg::DATA_W-1:0] v;
        int                                   slot;
        bit                                   dup;
        r        = '0;
        r.status = sulist_pkg::STAT_OK;
        v        = op.value;
        slot     = held_count;
        dup      = 1'b0;
        case (op.cmd)
            sulist_pkg::CMD_INSERT:
            begin
                for (int i = 0; i < held_count; i++)
                begin
                    if (held_vals[i] == v)
                    begin
                        dup = 1'b1;
                        break;
                    end
                    if (held_vals[i] < v)
                    begin
                        slot = i;
                        break;
                    end
                end
                if (dup)
                    r.status = sulist_pkg::STAT_MISS;
                else if (held_count >= sulist_pkg::CAPACITY)
                    r.status = sulist_pkg::STAT_FULL;
                else
                begin
                    for (int i = held_count; i > slot; i--)
                        held_vals[i] = held_vals[i-1];
                    held_vals[slot] = v;
                    held_count++;
                    r.found = sulist_pkg::POS_W'(slot + 1);
                end
            end
            sulist_pkg::CMD_REMOVE:
            begin
                if (op.pos >= 1 && op.pos <= held_count)
                begin
                    for (int i = op.pos - 1; i + 1 < held_count; i++)
                        held_vals[i] = held_vals[i+1];
                    held_count--;
                end
                else
                    r.status = sulist_pkg::STAT_RANGE;
            end
            sulist_pkg::CMD_GET:
            begin
                if (op.pos >= 1 && op.pos <= held_count)
                    r.item = held_vals[op.pos-1];
                else
                begin
                    r.item   = sulist_pkg::ITEM_NONE;
                    r.status = sulist_pkg::STAT_RANGE;
                end
            end
            sulist_pkg::CMD_SEARCH:
            begin
                r.status = sulist_pkg::STAT_MISS;
                for (int i = 0; i < held_count; i++)
                begin
                    if (held_vals[i] == v)
                    begin
                        r.status = sulist_pkg::STAT_OK;
                        r.found  = sulist_pkg::POS_W'(i + 1);
                        break;
                    end
                end
            end
            sulist_pkg::CMD_CLEAR:
                held_count = 0;
            default:
            begin
            end
        endcase
        r.count = sulist_pkg::CNT_W'(held_count);
        return r;
    endfunction

    task automatic send_op(input list_op_t op, input bit typed, input list_res_t want);
        list_res_t predicted;
        while (!calm && $urandom_range(99) < 15)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = apply_op(op);
        pending_results.push_back(typed ? want : predicted);
    endtask

    always @(posedge clk)
    begin
        m_axis_tready <= calm || ($urandom_range(99) >= 15);
    end

    always @(posedge clk)
    begin
        list_res_t got;
        list_res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected transaction, expected none got %h", $time, got);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.item !== want.item)
                begin
                    $display("%0t: item expected %h got %h", $time, want.item, got.item);
                    errors++;
                end
                if (got.status !== want.status)
                begin
                    $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
                    errors++;
                end
                if (got.found !== want.found)
                begin
                    $display("%0t: found_position expected %0d got %0d", $time, want.found,
                             got.found);
                    errors++;
                end
                if (got.count !== want.count)
                begin
                    $display("%0t: entry_count expected %0d got %0d", $time, want.count,
                             got.count);
                    errors++;
                end
                if (got.pad !== want.pad)
                begin
                    $display("%0t: padding expected %h got %h", $time, want.pad, got.pad);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #400000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        list_op_t                             op;
        logic signed [sulist_pkg::DATA_W-1:0] v;
        logic [sulist_pkg::CMD_W-1:0]         cmd;
        logic [sulist_pkg::POS_W-1:0]         pos;
        int                                   mode;
        int                                   r;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        errors        = 0;
        calm          = 1'b0;
        held_count    = 0;
        mode          = 2;

        add_row(mk_op(sulist_pkg::CMD_GET, '0, 5'd1), 1'b1,
                mk_res(sulist_pkg::ITEM_NONE, sulist_pkg::STAT_RANGE, 5'd0, 5'd0));
        add_row(mk_op(sulist_pkg::CMD_REMOVE, '0, 5'd0), 1'b1,
                mk_res('0, sulist_pkg::STAT_RANGE, 5'd0, 5'd0));
        add_row(mk_op(sulist_pkg::CMD_SEARCH, 32'sd5, 5'd0), 1'b1,
                mk_res('0, sulist_pkg::STAT_MISS, 5'd0, 5'd0));
        add_row(mk_op(sulist_pkg::CMD_INSERT, VAL_MAX, 5'd0), 1'b1,
                mk_res('0, sulist_pkg::STAT_OK, 5'd1, 5'd1));
        add_row(mk_op(sulist_pkg::CMD_INSERT, VAL_MIN, 5'd0), 1'b1,
                mk_res('0, sulist_pkg::STAT_OK, 5'd2, 5'd2));
        add_row(mk_op(sulist_pkg::CMD_INSERT, '0, 5'd0), 1'b1,
                mk_res('0, sulist_pkg::STAT_OK, 5'd2, 5'd3));
        add_row(mk_op(sulist_pkg::CMD_INSERT, '0, 5'd31), 1'b1,
                mk_res('0, sulist_pkg::STAT_MISS, 5'd0, 5'd3));
        add_row(mk_op(sulist_pkg::CMD_INSERT, -32'sd1, 5'd0), 1'b0, '0);
        add_row(mk_op(sulist_pkg::CMD_SEARCH, VAL_MIN, 5'd0), 1'b0, '0);
        add_row(mk_op(sulist_pkg::CMD_GET, '0, 5'd1), 1'b1,
                mk_res(VAL_MAX, sulist_pkg::STAT_OK, 5'd0, 5'd4));
        add_row(mk_op(sulist_pkg::CMD_GET, '0, 5'd4), 1'b1,
                mk_res(VAL_MIN, sulist_pkg::STAT_OK, 5'd0, 5'd4));
        add_row(mk_op(sulist_pkg::CMD_GET, '0, 5'd31), 1'b1,
                mk_res(sulist_pkg::ITEM_NONE, sulist_pkg::STAT_RANGE, 5'd0, 5'd4));
        add_row(mk_op(sulist_pkg::CMD_REMOVE, '0, 5'd5), 1'b1,
                mk_res('0, sulist_pkg::STAT_RANGE, 5'd0, 5'd4));
        add_row(mk_op(sulist_pkg::CMD_REMOVE, '0, 5'd1), 1'b0, '0);
        add_row(mk_op(sulist_pkg::CMD_REMOVE, '0, 5'd3), 1'b0, '0);
        add_row(mk_op(sulist_pkg::CMD_GET, '0, 5'd2), 1'b0, '0);
        add_row(mk_op(CMD_SPARE_LO, -32'sd1, 5'd31), 1'b0, '0);
        add_row(mk_op(CMD_SPARE_MID, VAL_MIN, 5'd16), 1'b0, '0);
        add_row(mk_op(CMD_SPARE_HI, VAL_MAX, 5'd1), 1'b0, '0);
        add_row(mk_op(sulist_pkg::CMD_SEARCH, -32'sd1, 5'd0), 1'b0, '0);
        add_row(mk_op(sulist_pkg::CMD_SEARCH, 32'sd5, 5'd0), 1'b0, '0);
        add_row(mk_op(sulist_pkg::CMD_CLEAR, '0, 5'd0), 1'b1,
                mk_res('0, sulist_pkg::STAT_OK, 5'd0, 5'd0));
        add_row(mk_op(sulist_pkg::CMD_REMOVE, '0, 5'd1), 1'b1,
                mk_res('0, sulist_pkg::STAT_RANGE, 5'd0, 5'd0));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (op_table[k])
            send_op(op_table[k].op, op_table[k].typed, op_table[k].res);

        // hold off until the pipe drains
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);

        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            if (n % 60 == 0)
                mode = $urandom_range(2);
            calm = (n >= 100 && n < 200);
            if (n == 250)
            begin
                s_axis_tvalid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
            end

            r = $urandom_range(99);
            if (mode == 0)
                cmd = (r < 65) ? sulist_pkg::CMD_INSERT : (r < 70) ? sulist_pkg::CMD_REMOVE :
                      (r < 82) ? sulist_pkg::CMD_GET : (r < 94) ? sulist_pkg::CMD_SEARCH :
                      (r < 96) ? sulist_pkg::CMD_CLEAR : CMD_SPARE_LO;
            else if (mode == 1)
                cmd = (r < 20) ? sulist_pkg::CMD_INSERT : (r < 65) ? sulist_pkg::CMD_REMOVE :
                      (r < 80) ? sulist_pkg::CMD_GET : (r < 93) ? sulist_pkg::CMD_SEARCH :
                      (r < 95) ? sulist_pkg::CMD_CLEAR : CMD_SPARE_LO;
            else
                cmd = (r < 40) ? sulist_pkg::CMD_INSERT : (r < 55) ? sulist_pkg::CMD_REMOVE :
                      (r < 72) ? sulist_pkg::CMD_GET : (r < 90) ? sulist_pkg::CMD_SEARCH :
                      (r < 95) ? sulist_pkg::CMD_CLEAR : CMD_SPARE_LO;
            if (cmd == CMD_SPARE_LO)
                cmd = sulist_pkg::CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));

            r = $urandom_range(9);
            if (r < 4 && held_count > 0)
                v = held_vals[$urandom_range(held_count - 1)];
            else if (r < 7)
                v = sulist_pkg::DATA_W'(int'($urandom_range(40)) - 20);
            else if (r == 7)
            begin
                case ($urandom_range(3))
                    0: v = VAL_MAX;
                    1: v = VAL_MIN;
                    2: v = '0;
                    default: v = -32'sd1;
                endcase
            end
            else
                v = $urandom;

            r = $urandom_range(9);
            if (r < 7)
                pos = (held_count > 0) ? sulist_pkg::POS_W'($urandom_range(held_count, 1)) : '0;
            else if (r == 7)
                pos = '0;
            else if (r == 8)
                pos = sulist_pkg::POS_W'(held_count + 1);
            else
                pos = sulist_pkg::POS_W'($urandom_range(31));

            op = mk_op(cmd, v, pos);
            send_op(op, 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;
        calm = 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
